>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
// Depends on nothing; users provide clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define PDVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge
`define PDVM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/pdvm_pkg.sv
// Package of the voice mixer: sizes, slot record, sine table builder.
// No dependencies.
package pdvm_pkg;

  localparam int VOICES          = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_Q          = 1 << SINE_TABLE_BITS;
  localparam int CNT_W           = $clog2(VOICES + 1);
  localparam int DIV_W           = 44;
  localparam int DVS_W           = 20;
  localparam int ACC_W           = 64;
  localparam int PIPE_DEPTH      = 4;

  // phase step = 1961 * pitch + (914 * pitch + 735) / 1470, by reciprocal
  localparam logic [10:0] STEP_INT      = 11'd1961;
  localparam logic [9:0]  STEP_FRAC_MUL = 10'd914;
  localparam logic [9:0]  STEP_FRAC_RND = 10'd735;
  localparam logic [26:0] STEP_RECIP    = 27'd93495887;
  localparam int          STEP_SHIFT    = 37;

  localparam logic [24:0] LEVEL_ONE   = 25'h1000000;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DEN [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                                 64'd156};

  typedef struct packed {
    logic        active;
    logic        shape;
    logic [31:0] phase;
    logic [31:0] step;
    logic [15:0] loud;
    logic [24:0] level;
    logic [24:0] decay;
  } slot_t;

  typedef struct packed {
    logic        valid;
    logic        shape;
    logic [31:0] phase;
    logic [15:0] loud;
    logic [24:0] level;
  } mix_in_t;

  typedef logic [15:0] sine_rom_t [SINE_Q + 1];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t      rom;
    longint unsigned x;
    longint unsigned t;
    longint          sum;
    longint          r;
    for (int k = 0; k <= SINE_Q; k++) begin
      x   = (HALF_PI_Q30 * longint'(k)) >> SINE_TABLE_BITS;
      t   = x;
      sum = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        t = (t * x) >> 30;
        t = ((t * x) >> 30) / TAYLOR_DEN[n - 1];
        if ((n % 2) == 1) sum = sum - longint'(t);
        else              sum = sum + longint'(t);
      end
      if (sum < 0) sum = 0;
      r = (sum + 16384) / 32768;
      if (r > 32767) r = 32767;
      rom[k] = r[15:0];
    end
    return rom;
  endfunction

endpackage

>>> rtl/core/pdvm_cell.sv
// One voice slot of the rotating slot chain.
// Depends on pdvm_pkg.
module pdvm_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  pdvm_pkg::slot_t d,
  output pdvm_pkg::slot_t q
);

  logic            active_r;
  pdvm_pkg::slot_t slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (shift) begin
      active_r <= d.active;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      slot_r <= d;
    end
  end

  always_comb begin
    q        = slot_r;
    q.active = active_r;
  end

endmodule

>>> rtl/core/pdvm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pdvm_pkg.
module pdvm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pdvm_pkg::DIV_W-1:0] dividend,
  input  logic [pdvm_pkg::DVS_W-1:0] divisor,
  output logic [31:0]                quotient,
  output logic                       done
);

  localparam int DC_W = $clog2(pdvm_pkg::DIV_W);

  logic                       busy_r;
  logic                       done_r;
  logic [DC_W-1:0]            cnt_r;
  logic [pdvm_pkg::DIV_W-1:0] dvd_r;
  logic [pdvm_pkg::DVS_W-1:0] rem_r;
  logic [pdvm_pkg::DVS_W-1:0] dvs_r;
  logic [pdvm_pkg::DVS_W:0]   trial;
  logic                       fits;

  assign trial = {rem_r, dvd_r[pdvm_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DC_W'(pdvm_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[pdvm_pkg::DIV_W-2:0], fits};
      rem_r <= fits ? pdvm_pkg::DVS_W'(trial - {1'b0, dvs_r})
                    : trial[pdvm_pkg::DVS_W-1:0];
    end
  end

  assign quotient = dvd_r[31:0];
  assign done     = done_r;

endmodule

>>> rtl/core/pdvm_mix.sv
// Wave lookup, gain multiply and accumulate pipeline with output saturation.
// Depends on pdvm_pkg; holds the quarter-wave sine ROM.
module pdvm_mix (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  pdvm_pkg::mix_in_t mi,
  output logic [15:0]       sample
);

  localparam int TB = pdvm_pkg::SINE_TABLE_BITS;
  localparam pdvm_pkg::sine_rom_t SineRom = pdvm_pkg::build_sine_rom();

  logic [TB:0]      idx;
  logic [TB-1:0]    qi;
  logic [31:0]      f;
  logic [16:0]      fs;
  logic signed [17:0] tri_w;
  logic signed [15:0] tri_c;

  logic               v1_r, v2_r, v3_r;
  logic               shape1_r, neg1_r;
  logic signed [15:0] tri1_r;
  logic [15:0]        rom1_r;
  logic [15:0]        loud1_r;
  logic [24:0]        level1_r, level2_r;
  logic signed [15:0] wave;
  logic signed [32:0] prod1_r;
  logic signed [58:0] prod2_r;
  logic signed [pdvm_pkg::ACC_W-1:0] acc_r;
  logic signed [pdvm_pkg::ACC_W-1:0] adj;

  assign qi  = mi.phase[29:30-TB];
  assign idx = mi.phase[30] ? (TB+1)'(pdvm_pkg::SINE_Q) - {1'b0, qi} : {1'b0, qi};

  assign f  = mi.phase + 32'h4000_0000;
  assign fs = f[31:15];
  always_comb begin
    if (!f[31]) tri_w = $signed({1'b0, fs}) - 18'sd32768;
    else        tri_w = 18'sd98304 - $signed({1'b0, fs});
    tri_c = (tri_w > 18'sd32767) ? 16'sd32767 : tri_w[15:0];
  end

  always_ff @(posedge clk) begin
    rom1_r   <= SineRom[idx];
    shape1_r <= mi.shape;
    neg1_r   <= mi.phase[31];
    tri1_r   <= tri_c;
    loud1_r  <= mi.loud;
    level1_r <= mi.level;
  end

  assign wave = shape1_r ? tri1_r : (neg1_r ? -$signed(rom1_r) : $signed(rom1_r));

  always_ff @(posedge clk) begin
    prod1_r  <= wave * $signed({1'b0, loud1_r});
    level2_r <= level1_r;
    prod2_r  <= prod1_r * $signed({1'b0, level2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      v1_r <= mi.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (clear) begin
        acc_r <= '0;
      end else if (v3_r) begin
        acc_r <= acc_r + pdvm_pkg::ACC_W'(prod2_r);
      end
    end
  end

  // truncate toward zero
  assign adj = acc_r + (acc_r[pdvm_pkg::ACC_W-1] ? pdvm_pkg::ACC_W'(64'hFF_FFFF_FFFF) : '0);

  always_comb begin
    if (acc_r >= (pdvm_pkg::ACC_W'(1) <<< 55)) begin
      sample = 16'h7FFF;
    end else if (acc_r < -(pdvm_pkg::ACC_W'(1) <<< 55)) begin
      sample = 16'h8000;
    end else begin
      sample = adj[55:40];
    end
  end

endmodule

>>> rtl/core/polyphonic_decay_voice_mixer_top.sv
// Polyphonic decay voice mixer, top level: slot chain, divider, mixer.
// Depends on pdvm_pkg, pdvm_cell, pdvm_div, pdvm_mix, assert_macros.svh.
// Tick: the slot chain rotates once around, then the mix pipeline drains. Add voice:
// the decay divider runs, then the slot chain rotates; one request at a time, set by the
// rotation of the slot chain and the serial decay divider.
// Reset (synchronous) empties every slot at once; results cannot be stalled.
`include "assert_macros.svh"
module polyphonic_decay_voice_mixer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic        in_shape,
  input  logic [15:0] in_loudness,
  input  logic [15:0] in_pitch,
  input  logic [19:0] in_duration_samples,
  output logic        out_strobe,
  output logic signed [15:0] out_sample,
  output logic        out_sample_valid,
  output logic        out_voice_dropped
);

  localparam int V = pdvm_pkg::VOICES;
  localparam int CW = pdvm_pkg::CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIVD  = 4'b0010,
    ST_ROT   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic            accept;
  logic            tick_r;
  logic            shape_r;
  logic [15:0]     loud_r;
  logic [25:0]     frac_r;
  logic [31:0]     base_r;
  logic [52:0]     step_prod;
  logic [31:0]     step_r;
  logic [24:0]     decay_r;
  logic            placed_r, placed_nxt;
  logic [CW-1:0]   cnt_r;
  logic [2:0]      drain_r;
  logic            strobe_r;
  logic [15:0]     sample_r;
  logic            sv_r, vd_r;

  logic                       div_start;
  logic [pdvm_pkg::DIV_W-1:0] div_dvd;
  logic [pdvm_pkg::DVS_W-1:0] div_dvs;
  logic [31:0]                div_q;
  logic                       div_done;
  logic [19:0]                dur_eff;

  pdvm_pkg::slot_t   cell_q [V];
  pdvm_pkg::slot_t   head, head_nxt;
  pdvm_pkg::mix_in_t mi;
  logic              shift;
  logic [15:0]       mix_sample;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign shift  = (state_r == ST_ROT);
  assign dur_eff = (in_duration_samples == 20'd0) ? 20'd1 : in_duration_samples;

  assign div_start = accept && !in_action;
  assign div_dvd   = pdvm_pkg::DIV_W'(pdvm_pkg::LEVEL_ONE) + pdvm_pkg::DIV_W'(dur_eff >> 1);
  assign div_dvs   = dur_eff;

  assign step_prod = 53'(frac_r) * 53'(pdvm_pkg::STEP_RECIP);

  pdvm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  assign head = cell_q[0];

  always_comb begin
    head_nxt   = head;
    placed_nxt = placed_r;
    if (tick_r) begin
      if (head.active) begin
        if (head.level >= head.decay) begin
          head_nxt.level = head.level - head.decay;
          head_nxt.phase = head.phase + head.step;
        end else begin
          head_nxt.active = 1'b0;
        end
      end
    end else if (!placed_r && !head.active) begin
      head_nxt.active = 1'b1;
      head_nxt.shape  = shape_r;
      head_nxt.phase  = '0;
      head_nxt.step   = step_r;
      head_nxt.loud   = loud_r;
      head_nxt.level  = pdvm_pkg::LEVEL_ONE;
      head_nxt.decay  = decay_r;
      placed_nxt      = 1'b1;
    end
  end

  for (genvar i = 0; i < V; i++) begin : g_cell
    pdvm_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (shift),
      .d     ((i == V - 1) ? head_nxt : cell_q[(i + 1) % V]),
      .q     (cell_q[i])
    );
  end

  always_comb begin
    mi.valid = shift && tick_r && head.active;
    mi.shape = head.shape;
    mi.phase = head.phase;
    mi.loud  = head.loud;
    mi.level = head.level;
  end

  pdvm_mix u_mix (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (accept),
    .mi     (mi),
    .sample (mix_sample)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = in_action ? ST_ROT : ST_DIVD;
      ST_DIVD:  if (div_done) state_nxt = ST_ROT;
      ST_ROT:   if (cnt_r == CW'(V - 1)) state_nxt = tick_r ? ST_DRAIN : ST_IDLE;
      ST_DRAIN: if (drain_r == 3'(pdvm_pkg::PIPE_DEPTH - 1)) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      drain_r  <= '0;
      placed_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= 1'b0;
      if (accept) begin
        cnt_r    <= '0;
        drain_r  <= '0;
        placed_r <= 1'b0;
      end
      if (state_r == ST_ROT) begin
        cnt_r    <= cnt_r + 1'b1;
        placed_r <= placed_nxt;
        if (cnt_r == CW'(V - 1) && !tick_r) strobe_r <= 1'b1;
      end
      if (state_r == ST_DRAIN) begin
        drain_r <= drain_r + 1'b1;
        if (drain_r == 3'(pdvm_pkg::PIPE_DEPTH - 1)) strobe_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tick_r  <= in_action;
      shape_r <= in_shape;
      loud_r  <= in_loudness;
      frac_r  <= 26'(in_pitch) * 26'(pdvm_pkg::STEP_FRAC_MUL)
               + 26'(pdvm_pkg::STEP_FRAC_RND);
      base_r  <= 32'(in_pitch) * 32'(pdvm_pkg::STEP_INT);
    end
    if (state_r == ST_DIVD) step_r <= base_r + 32'(step_prod >> pdvm_pkg::STEP_SHIFT);
    if (state_r == ST_DIVD && div_done) decay_r <= div_q[24:0];
    if (state_r == ST_ROT && cnt_r == CW'(V - 1) && !tick_r) begin
      sample_r <= '0;
      sv_r     <= 1'b0;
      vd_r     <= !placed_nxt;
    end
    if (state_r == ST_DRAIN) begin
      sample_r <= mix_sample;
      sv_r     <= 1'b1;
      vd_r     <= 1'b0;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_sample        = sample_r;
  assign out_sample_valid  = sv_r;
  assign out_voice_dropped = vd_r;

  `PDVM_ASSERT(a_accept_busy, accept |=> busy, "request not taken up")
  `PDVM_ASSERT(a_one_result, out_strobe |=> !out_strobe, "result repeated")
  `PDVM_ASSERT(a_flags, out_strobe |-> !(out_sample_valid && out_voice_dropped),
               "tick flagged as drop")
  `PDVM_ASSERT(a_add_silent, (out_strobe && !out_sample_valid) |-> (out_sample == 16'sd0),
               "add request carries audio")
  `PDVM_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !busy && !out_strobe, "reset not idle")

endmodule
